/* design/prol_pkg.sv */
// Shared constants, codes and controller/datapath interface types.
package prol_pkg;

  // Fixed field widths.
  localparam int OP_W     = 2;
  localparam int HANDLE_W = 12;
  localparam int H_W      = 16;
  localparam int KEY_W    = 16;
  localparam int ID_W     = 32;
  localparam int RAND_W   = 32;
  localparam int STATUS_W = 3;
  localparam int KC_W     = 16;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd2;
  localparam logic [STATUS_W-1:0] ST_PART_FULL  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_KEY_EXH    = 3'd4;

  // Sentinel record and key counter limit.
  localparam logic [ID_W-1:0]  ID_NONE   = 32'hFFFF_FFFF;
  localparam logic [H_W-1:0]   H_INF     = 16'hFFFF;
  localparam logic [KEY_W-1:0] KEY_NONE  = 16'hFFFF;
  localparam logic [KC_W-1:0]  KEY_LIMIT = 16'h8000;

  // Read address selects.
  typedef enum logic [1:0] {TSEL_IDX, TSEL_PI, TSEL_LAST} tbl_sel_e;
  typedef enum logic {ESEL_POS, ESEL_LAST} ent_sel_e;
  typedef enum logic {DSEL_PART, DSEL_ENTRY} div_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                ld_in;
    logic                upd_cur;
    logic                calc_key;
    logic                idx_inc;
    logic                cap_ent;
    logic                cap_new;
    logic                append;
    logic                div_start;
    div_sel_e            div_sel;
    logic                cap_pi;
    logic                cap_pos;
    tbl_sel_e            tsel;
    ent_sel_e            esel;
    logic                cap_removed;
    logic                ent_wr_pos;
    logic                tbl_shrink;
    logic                tbl_move;
    logic                tbl_free;
    logic                cnt_dec;
    logic                clear;
    logic                set_status;
    logic [STATUS_W-1:0] status_code;
    logic                out_load;
  } prol_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            count_zero;
    logic            idx_at_count;
    logic            table_full;
    logic            key_exh;
    logic            key_match;
    logic            part_full;
    logic            size_bad;
    logic            size_one;
    logic            pi_is_last;
    logic            div_done;
    logic            out_busy;
  } prol_sts_t;

endpackage

/* design/prol_ram.sv */
// Generic simple dual-port RAM with registered read.
module prol_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/prol_div.sv */
// Bit-serial remainder unit: one dividend bit per cycle.
module prol_div
  import prol_pkg::*;
#(
  parameter int DW = 9
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [RAND_W-1:0] dividend_i,
  input  logic [DW-1:0]     divisor_i,
  output logic              done_o,
  output logic [DW-1:0]     rem_o
);

  localparam int CNTW = $clog2(RAND_W);

  logic            busy_q, done_q;
  logic [CNTW-1:0] cnt_q;
  logic [RAND_W-1:0] dvd_q;
  logic [DW-1:0]   rem_q, dsr_q;
  logic [DW:0]     trial;
  logic            ge;
  logic [DW-1:0]   rem_d;

  // Shift in the next dividend bit and subtract when it fits.
  always_comb begin
    trial = {rem_q, dvd_q[RAND_W-1]};
    ge    = trial >= {1'b0, dsr_q};
    rem_d = ge ? DW'(trial - {1'b0, dsr_q}) : DW'(trial);
  end

  // Control of the iteration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNTW'(1);
        if (cnt_q == CNTW'(RAND_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operand and partial remainder registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_q << 1;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

/* design/prol_dp.sv */
// Datapath: records, partition table, entry store, counters and result registers.
module prol_dp
  import prol_pkg::*;
#(
  parameter int MAX_STATES      = 4096,
  parameter int MAX_PARTITIONS  = 256,
  parameter int PARTITION_DEPTH = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  prol_cmd_t            cmd_i,
  output prol_sts_t            sts_o,
  input  logic [OP_W-1:0]      operation_i,
  input  logic [HANDLE_W-1:0]  state_handle_i,
  input  logic                 has_parent_i,
  input  logic [HANDLE_W-1:0]  parent_handle_i,
  input  logic [H_W-1:0]       h_value_i,
  input  logic [RAND_W-1:0]    rand_part_i,
  input  logic [RAND_W-1:0]    rand_entry_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output logic [HANDLE_W-1:0]  removed_state_o,
  output logic signed [KEY_W-1:0] assigned_key_o,
  output logic [STATUS_W-1:0]  status_o,
  output logic                 now_empty_o
);

  localparam int SAW  = $clog2(MAX_STATES);
  localparam int MSW  = $clog2(MAX_STATES + 1);
  localparam int CW   = $clog2(MAX_PARTITIONS + 1);
  localparam int RW   = $clog2(MAX_PARTITIONS);
  localparam int SW   = $clog2(PARTITION_DEPTH + 1);
  localparam int PW   = $clog2(PARTITION_DEPTH);
  localparam int EDEP = MAX_PARTITIONS * PARTITION_DEPTH;
  localparam int EAW  = $clog2(EDEP);
  localparam int DW   = (CW > SW) ? CW : SW;
  localparam int TW   = KEY_W + SW + RW;
  localparam int RECW = ID_W + H_W + KEY_W;
  // Handle reduction modulo the record store depth by reciprocal multiply.
  localparam int SHF  = HANDLE_W + SAW;
  localparam int RCPW = HANDLE_W + 2;
  localparam int PRW  = HANDLE_W + RCPW;
  localparam int MW   = HANDLE_W + MSW;
  localparam longint RCP_L = ((longint'(1) << SHF) + longint'(MAX_STATES) - 1)
                             / longint'(MAX_STATES);
  localparam logic [RCPW-1:0] RCP = RCPW'(RCP_L);

  // Latched input beat.
  logic [OP_W-1:0]     op_q;
  logic [HANDLE_W-1:0] handle_q, parent_q;
  logic                hp_q;
  logic [H_W-1:0]      h_q;
  logic [RAND_W-1:0]   rpart_q, rentry_q;

  // Control state.
  logic [CW-1:0]    count_q;
  logic [ID_W-1:0]  cur_id_q;
  logic [H_W-1:0]   cur_h_q;
  logic [KEY_W-1:0] cur_key_q;
  logic             flag_q;
  logic [ID_W-1:0]  serial_q;
  logic [KC_W-1:0]  kc_q;
  logic [MAX_PARTITIONS-1:0] vld_q;
  logic             out_valid_q;

  // Working registers.
  logic [KEY_W-1:0] key_q, ekey_q;
  logic             fresh_q, new_q;
  logic [CW-1:0]    idx_q;
  logic [SW-1:0]    size_q;
  logic [RW-1:0]    row_q, pi_q, tra_q;
  logic [PW-1:0]    pos_q;
  logic [PRW-1:0]   prodp_q, prodh_q;
  logic [MW-1:0]    mulp_q, mulh_q;
  logic [HANDLE_W-1:0] removed_q, out_removed_q;
  logic [KEY_W-1:0] res_key_q, out_key_q;
  logic [STATUS_W-1:0] res_status_q, out_status_q;
  logic             out_empty_q;

  // Memory ports.
  logic [SAW-1:0]   pidx, hidx;
  logic [RECW-1:0]  rec_rd;
  logic [ID_W-1:0]  rid;
  logic [H_W-1:0]   rh;
  logic [KEY_W-1:0] rkey;
  logic             twe;
  logic [RW-1:0]    twa, tra, last_idx;
  logic [TW-1:0]    twd, trd;
  logic [KEY_W-1:0] tkey;
  logic [SW-1:0]    tsize;
  logic [RW-1:0]    trow;
  logic             ewe;
  logic [EAW-1:0]   ebase, ewa, era;
  logic [HANDLE_W-1:0] ewd, erd;
  logic             div_done;
  logic [DW-1:0]    div_rem;
  logic [RAND_W-1:0] div_dvd;
  logic [DW-1:0]    div_dsr;

  // Key choice.
  logic             need_new;
  logic [KEY_W-1:0] key_d;
  logic             fresh_d;

  // Record indexes.
  assign pidx = SAW'(MW'(parent_q) - mulp_q);
  assign hidx = SAW'(MW'(handle_q) - mulh_q);
  assign rid  = rec_rd[RECW-1 -: ID_W];
  assign rh   = rec_rd[KEY_W +: H_W];
  assign rkey = rec_rd[KEY_W-1:0];

  // Partition table read; a row never written is its own index.
  assign last_idx = RW'(count_q - CW'(1));
  always_comb begin
    case (cmd_i.tsel)
      TSEL_IDX:  tra = idx_q[RW-1:0];
      TSEL_PI:   tra = pi_q;
      TSEL_LAST: tra = last_idx;
      default:   tra = idx_q[RW-1:0];
    endcase
  end
  assign tkey  = trd[TW-1 -: KEY_W];
  assign tsize = trd[RW +: SW];
  assign trow  = vld_q[tra_q] ? trd[RW-1:0] : tra_q;

  // Partition table write.
  always_comb begin
    twe = 1'b0;
    twa = idx_q[RW-1:0];
    twd = '0;
    if (cmd_i.append) begin
      twe = 1'b1;
      twd = {key_q, size_q + SW'(1), row_q};
    end else if (cmd_i.tbl_shrink) begin
      twe = 1'b1;
      twa = pi_q;
      twd = {ekey_q, size_q - SW'(1), row_q};
    end else if (cmd_i.tbl_move) begin
      twe = 1'b1;
      twa = pi_q;
      twd = {tkey, tsize, trow};
    end else if (cmd_i.tbl_free) begin
      twe = 1'b1;
      twa = last_idx;
      twd = {KEY_NONE, SW'(0), row_q};
    end
  end

  // Entry store addressing.
  assign ebase = EAW'(row_q) * EAW'(PARTITION_DEPTH);
  always_comb begin
    case (cmd_i.esel)
      ESEL_POS:  era = ebase + EAW'(pos_q);
      ESEL_LAST: era = ebase + EAW'(size_q - SW'(1));
      default:   era = ebase + EAW'(pos_q);
    endcase
    ewe = cmd_i.append | cmd_i.ent_wr_pos;
    if (cmd_i.append) begin
      ewa = ebase + EAW'(size_q);
      ewd = handle_q;
    end else begin
      ewa = ebase + EAW'(pos_q);
      ewd = erd;
    end
  end

  // Key selection after the current record update.
  always_comb begin
    need_new = h_q < cur_h_q;
    fresh_d  = 1'b0;
    if (need_new && flag_q) begin
      key_d   = KEY_W'(kc_q);
      fresh_d = 1'b1;
    end else if (need_new) begin
      key_d = KEY_W'(kc_q - KC_W'(1));
    end else begin
      key_d = cur_key_q;
    end
  end

  // Divider operands.
  assign div_dvd = (cmd_i.div_sel == DSEL_PART) ? rpart_q : rentry_q;
  assign div_dsr = (cmd_i.div_sel == DSEL_PART) ? DW'(count_q) : DW'(size_q);

  prol_ram #(.WIDTH(RECW), .DEPTH(MAX_STATES)) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.append),
    .waddr_i (hidx),
    .wdata_i ({serial_q, h_q, key_q}),
    .raddr_i (pidx),
    .rdata_o (rec_rd)
  );

  prol_ram #(.WIDTH(TW), .DEPTH(MAX_PARTITIONS)) u_tbl_ram (
    .clk_i   (clk_i),
    .we_i    (twe),
    .waddr_i (twa),
    .wdata_i (twd),
    .raddr_i (tra),
    .rdata_o (trd)
  );

  prol_ram #(.WIDTH(HANDLE_W), .DEPTH(EDEP)) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (ewe),
    .waddr_i (ewa),
    .wdata_i (ewd),
    .raddr_i (era),
    .rdata_o (erd)
  );

  prol_div #(.DW(DW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // Persistent search state and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      cur_id_q    <= ID_NONE;
      cur_h_q     <= H_INF;
      cur_key_q   <= KEY_NONE;
      flag_q      <= 1'b1;
      serial_q    <= '0;
      kc_q        <= '0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        count_q <= '0;
      end else if (cmd_i.append && new_q) begin
        count_q <= count_q + CW'(1);
      end else if (cmd_i.cnt_dec) begin
        count_q <= count_q - CW'(1);
      end
      if (cmd_i.upd_cur) begin
        if (!hp_q) begin
          cur_id_q  <= ID_NONE;
          cur_h_q   <= H_INF;
          cur_key_q <= KEY_NONE;
        end else if (rid != cur_id_q) begin
          cur_id_q  <= rid;
          cur_h_q   <= rh;
          cur_key_q <= rkey;
          flag_q    <= 1'b1;
        end
      end
      if (cmd_i.append) begin
        serial_q <= serial_q + ID_W'(1);
        if (fresh_q) begin
          kc_q   <= kc_q + KC_W'(1);
          flag_q <= 1'b0;
        end
      end
      if (twe) begin
        vld_q[twa] <= 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk_i) begin
    tra_q   <= tra;
    prodp_q <= PRW'(parent_q) * PRW'(RCP);
    prodh_q <= PRW'(handle_q) * PRW'(RCP);
    mulp_q  <= MW'(HANDLE_W'(prodp_q >> SHF)) * MW'(MAX_STATES);
    mulh_q  <= MW'(HANDLE_W'(prodh_q >> SHF)) * MW'(MAX_STATES);
    if (cmd_i.ld_in) begin
      op_q         <= operation_i;
      handle_q     <= state_handle_i;
      hp_q         <= has_parent_i;
      parent_q     <= parent_handle_i;
      h_q          <= h_value_i;
      rpart_q      <= rand_part_i;
      rentry_q     <= rand_entry_i;
      res_status_q <= ST_OK;
      res_key_q    <= '0;
      removed_q    <= '0;
    end
    if (cmd_i.calc_key) begin
      key_q   <= key_d;
      fresh_q <= fresh_d;
      idx_q   <= '0;
    end
    if (cmd_i.idx_inc) begin
      idx_q <= idx_q + CW'(1);
    end
    if (cmd_i.cap_ent) begin
      size_q <= cmd_i.cap_new ? SW'(0) : tsize;
      row_q  <= trow;
      ekey_q <= tkey;
      new_q  <= cmd_i.cap_new;
    end
    if (cmd_i.cap_pi) begin
      pi_q <= RW'(div_rem);
    end
    if (cmd_i.cap_pos) begin
      pos_q <= PW'(div_rem);
    end
    if (cmd_i.cap_removed) begin
      removed_q <= erd;
    end
    if (cmd_i.append) begin
      res_key_q <= key_q;
    end
    if (cmd_i.set_status) begin
      res_status_q <= cmd_i.status_code;
    end
    if (cmd_i.out_load) begin
      out_removed_q <= removed_q;
      out_key_q     <= res_key_q;
      out_status_q  <= res_status_q;
      out_empty_q   <= count_q == '0;
    end
  end

  // Status toward the controller.
  always_comb begin
    sts_o.op           = op_q;
    sts_o.count_zero   = count_q == '0;
    sts_o.idx_at_count = idx_q == count_q;
    sts_o.table_full   = count_q == CW'(MAX_PARTITIONS);
    sts_o.key_exh      = need_new && flag_q && (kc_q >= KEY_LIMIT);
    sts_o.key_match    = tkey == key_q;
    sts_o.part_full    = tsize >= SW'(PARTITION_DEPTH);
    sts_o.size_bad     = (tsize == '0) || (tsize > SW'(PARTITION_DEPTH));
    sts_o.size_one     = size_q == SW'(1);
    sts_o.pi_is_last   = pi_q == last_idx;
    sts_o.div_done     = div_done;
    sts_o.out_busy     = out_valid_q && out_stall_i;
  end

  assign out_valid_o     = out_valid_q;
  assign removed_state_o = out_removed_q;
  assign assigned_key_o  = out_key_q;
  assign status_o        = out_status_q;
  assign now_empty_o     = out_empty_q;

endmodule

/* design/prol_ctrl.sv */
// Controller: sequences one operation at a time over the datapath.
module prol_ctrl
  import prol_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  prol_sts_t sts_i,
  output prol_cmd_t cmd_o
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_DISP  = 5'd1;
  localparam logic [4:0] S_IX    = 5'd2;
  localparam logic [4:0] S_RRD   = 5'd3;
  localparam logic [4:0] S_REC   = 5'd4;
  localparam logic [4:0] S_KEY   = 5'd5;
  localparam logic [4:0] S_SRD   = 5'd6;
  localparam logic [4:0] S_SCK   = 5'd7;
  localparam logic [4:0] S_OPEN  = 5'd8;
  localparam logic [4:0] S_APP   = 5'd9;
  localparam logic [4:0] S_DPW   = 5'd10;
  localparam logic [4:0] S_RP    = 5'd11;
  localparam logic [4:0] S_RS    = 5'd12;
  localparam logic [4:0] S_DES   = 5'd13;
  localparam logic [4:0] S_DEW   = 5'd14;
  localparam logic [4:0] S_RPOS  = 5'd15;
  localparam logic [4:0] S_RLAST = 5'd16;
  localparam logic [4:0] S_WPOS  = 5'd17;
  localparam logic [4:0] S_SHR   = 5'd18;
  localparam logic [4:0] S_MOVE  = 5'd19;
  localparam logic [4:0] S_FREE  = 5'd20;
  localparam logic [4:0] S_FIN   = 5'd21;

  logic [4:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = state_q != S_IDLE;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.ld_in = 1'b1;
          state_d     = S_DISP;
        end
      end
      S_DISP: begin
        case (sts_i.op)
          OP_INSERT: state_d = S_IX;
          OP_REMOVE: begin
            if (sts_i.count_zero) begin
              cmd_o.set_status  = 1'b1;
              cmd_o.status_code = ST_EMPTY;
              state_d           = S_FIN;
            end else begin
              cmd_o.div_start = 1'b1;
              cmd_o.div_sel   = DSEL_PART;
              state_d         = S_DPW;
            end
          end
          OP_CLEAR: begin
            cmd_o.clear = 1'b1;
            state_d     = S_FIN;
          end
          default: state_d = S_FIN;
        endcase
      end
      // Insert: handle reduction, parent record read, key choice.
      S_IX:  state_d = S_RRD;
      S_RRD: state_d = S_REC;
      S_REC: begin
        cmd_o.upd_cur = 1'b1;
        state_d       = S_KEY;
      end
      S_KEY: begin
        if (sts_i.key_exh) begin
          cmd_o.set_status  = 1'b1;
          cmd_o.status_code = ST_KEY_EXH;
          state_d           = S_FIN;
        end else begin
          cmd_o.calc_key = 1'b1;
          state_d        = S_SRD;
        end
      end
      // Linear search of the partition keys.
      S_SRD: begin
        cmd_o.tsel = TSEL_IDX;
        if (sts_i.idx_at_count) begin
          if (sts_i.table_full) begin
            cmd_o.set_status  = 1'b1;
            cmd_o.status_code = ST_TABLE_FULL;
            state_d           = S_FIN;
          end else begin
            state_d = S_OPEN;
          end
        end else begin
          state_d = S_SCK;
        end
      end
      S_SCK: begin
        if (sts_i.key_match) begin
          if (sts_i.part_full) begin
            cmd_o.set_status  = 1'b1;
            cmd_o.status_code = ST_PART_FULL;
            state_d           = S_FIN;
          end else begin
            cmd_o.cap_ent = 1'b1;
            state_d       = S_APP;
          end
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_SRD;
        end
      end
      S_OPEN: begin
        cmd_o.cap_ent = 1'b1;
        cmd_o.cap_new = 1'b1;
        state_d       = S_APP;
      end
      S_APP: begin
        cmd_o.append = 1'b1;
        state_d      = S_FIN;
      end
      // Remove: pick partition and entry, swap-pop.
      S_DPW: begin
        cmd_o.div_sel = DSEL_PART;
        if (sts_i.div_done) begin
          cmd_o.cap_pi = 1'b1;
          state_d      = S_RP;
        end
      end
      S_RP: begin
        cmd_o.tsel = TSEL_PI;
        state_d    = S_RS;
      end
      S_RS: begin
        if (sts_i.size_bad) begin
          cmd_o.set_status  = 1'b1;
          cmd_o.status_code = ST_EMPTY;
          state_d           = S_FIN;
        end else begin
          cmd_o.cap_ent = 1'b1;
          state_d       = S_DES;
        end
      end
      S_DES: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DSEL_ENTRY;
        state_d         = S_DEW;
      end
      S_DEW: begin
        cmd_o.div_sel = DSEL_ENTRY;
        if (sts_i.div_done) begin
          cmd_o.cap_pos = 1'b1;
          state_d       = S_RPOS;
        end
      end
      S_RPOS: begin
        cmd_o.esel = ESEL_POS;
        state_d    = S_RLAST;
      end
      S_RLAST: begin
        cmd_o.cap_removed = 1'b1;
        cmd_o.esel        = ESEL_LAST;
        state_d           = S_WPOS;
      end
      S_WPOS: begin
        cmd_o.ent_wr_pos = 1'b1;
        state_d          = S_SHR;
      end
      S_SHR: begin
        if (!sts_i.size_one) begin
          cmd_o.tbl_shrink = 1'b1;
          state_d          = S_FIN;
        end else if (sts_i.pi_is_last) begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_FIN;
        end else begin
          cmd_o.tsel = TSEL_LAST;
          state_d    = S_MOVE;
        end
      end
      S_MOVE: begin
        cmd_o.tbl_move = 1'b1;
        state_d        = S_FREE;
      end
      S_FREE: begin
        cmd_o.tbl_free = 1'b1;
        cmd_o.cnt_dec  = 1'b1;
        state_d        = S_FIN;
      end
      // Hand the result to the output register.
      S_FIN: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

/* design/partitioned_random_open_list.sv */
// Top level of the partitioned random open list.
//
//   Channel | Handshake             | Beat contents
//   --------+-----------------------+----------------------------------------------
//   input   | in_valid_i/in_stall_o | operation, handles, has_parent, h, two draws
//   output  | out_valid_o/out_stall_i | removed_state, assigned_key, status, now_empty
//
// One item is in work at a time. An insert's time grows with each
// partition key compared in the linear key search over the partition table.
// A remove is dominated by two bit-serial remainder passes over 32-bit draws.
// Clear and unknown ops only dispatch and deliver. Reset takes effect at once.
// A result waiting under out_stall_i holds the output register; the next beat is
// still accepted and finishes up to the point of delivery.
module partitioned_random_open_list
  import prol_pkg::*;
#(
  parameter int MAX_STATES      = 4096,
  parameter int MAX_PARTITIONS  = 256,
  parameter int PARTITION_DEPTH = 256
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [OP_W-1:0]         operation_i,
  input  logic [HANDLE_W-1:0]     state_handle_i,
  input  logic                    has_parent_i,
  input  logic [HANDLE_W-1:0]     parent_handle_i,
  input  logic [H_W-1:0]          h_value_i,
  input  logic [RAND_W-1:0]       rand_part_i,
  input  logic [RAND_W-1:0]       rand_entry_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [HANDLE_W-1:0]     removed_state_o,
  output logic signed [KEY_W-1:0] assigned_key_o,
  output logic [STATUS_W-1:0]     status_o,
  output logic                    now_empty_o
);

  prol_cmd_t cmd;
  prol_sts_t sts;

  prol_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  prol_dp #(
    .MAX_STATES      (MAX_STATES),
    .MAX_PARTITIONS  (MAX_PARTITIONS),
    .PARTITION_DEPTH (PARTITION_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .operation_i     (operation_i),
    .state_handle_i  (state_handle_i),
    .has_parent_i    (has_parent_i),
    .parent_handle_i (parent_handle_i),
    .h_value_i       (h_value_i),
    .rand_part_i     (rand_part_i),
    .rand_entry_i    (rand_entry_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .removed_state_o (removed_state_o),
    .assigned_key_o  (assigned_key_o),
    .status_o        (status_o),
    .now_empty_o     (now_empty_o)
  );

endmodule
